[rtl/core/lsub_pkg.sv]
package lsub_pkg;

    localparam int unsigned LSUB_MEM_BYTES = 65536;
    localparam int unsigned LSUB_LANES     = 8;
    localparam int unsigned LSUB_LANE_W    = 3;
    localparam int unsigned LSUB_DATA_W    = 64;

    // opcodes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_STORE = 1'b1;

    // access size codes
    localparam logic [1:0] SZ_BYTE   = 2'd0;
    localparam logic [1:0] SZ_HALF   = 2'd1;
    localparam logic [1:0] SZ_WORD   = 2'd2;
    localparam logic [1:0] SZ_DOUBLE = 2'd3;

    typedef logic [7:0] lsub_byte_t;

    // what the load alignment needs about an access in flight
    typedef struct packed {
        logic                   is_store;
        logic [1:0]             size_log2;
        logic                   sign_extend;
        logic [LSUB_LANE_W-1:0] lane;
    } lsub_ld_info_t;

endpackage

[rtl/core/lsub_req_if.sv]
interface lsub_req_if;
    logic               valid;
    logic               ready;
    logic               opcode;
    logic [1:0]         size_log2;
    logic               sign_extend;
    logic signed [63:0] base_value;
    logic signed [11:0] offset;
    logic signed [63:0] store_value;

    modport source (
        output valid, opcode, size_log2, sign_extend, base_value, offset, store_value,
        input  ready
    );
    modport sink (
        input  valid, opcode, size_log2, sign_extend, base_value, offset, store_value,
        output ready
    );
endinterface

[rtl/core/lsub_rsp_if.sv]
interface lsub_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] load_value;

    modport source (
        output valid, load_value,
        input  ready
    );
    modport sink (
        input  valid, load_value,
        output ready
    );
endinterface

[rtl/core/load_store_unit_byte_memory_top.sv]
// a result passes the bank read and item info registers, then the output register
// throughput: one item per cycle with rsp ready, set by one access per bank per cycle
// the memory is eight byte-wide single-port banks, each access touches every bank once
// reset: clears the pipeline valid flags only, memory contents are undefined until stored
// MEM_BYTES must be a power of two
module load_store_unit_byte_memory_top
    import lsub_pkg::*;
#(
    parameter int unsigned MEM_BYTES = LSUB_MEM_BYTES
) (
    input  logic       clk,
    input  logic       rst_n,
    lsub_req_if.sink   req,
    lsub_rsp_if.source rsp
);

    localparam int unsigned ADDR_W = $clog2(MEM_BYTES);
    localparam int unsigned ROW_W  = ADDR_W - LSUB_LANE_W;
    localparam int unsigned ROWS   = MEM_BYTES / LSUB_LANES;

    // handshake and pipeline control
    logic          acc;
    logic          advance;
    logic          s1_valid_reg;
    logic          s1_valid_next;
    lsub_ld_info_t s1_info_reg;
    lsub_ld_info_t s1_info_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    logic [63:0]   out_data_reg;
    logic [63:0]   out_data_next;

    // bank interface
    logic [ROW_W-1:0]       row_addr [LSUB_LANES];
    logic                   wen [LSUB_LANES];
    lsub_byte_t             wdata [LSUB_LANES];
    lsub_byte_t             rdata [LSUB_LANES];
    logic [LSUB_LANE_W-1:0] lane;
    logic [63:0]            aligned;

    // stage 1 moves to the output register when that is empty or being drained;
    // bank read data holds while stage 1 waits since banks only read on accept
    assign advance   = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || advance;
    assign acc       = req.valid && req.ready;

    // address, bank rows, byte enables and store lane steering
    lsub_addr_gen #(
        .MEM_BYTES (MEM_BYTES)
    ) u_addr_gen (
        .acc         (acc),
        .opcode      (req.opcode),
        .size_log2   (req.size_log2),
        .base_value  (req.base_value),
        .offset      (req.offset),
        .store_value (req.store_value),
        .row_addr    (row_addr),
        .wen         (wen),
        .wdata       (wdata),
        .lane        (lane)
    );

    // one byte bank per lane; a store writes its lanes, the other lanes do a dummy read
    for (genvar b = 0; b < LSUB_LANES; b++)
    begin : g_bank
        lsub_bank #(
            .DEPTH (ROWS)
        ) u_bank (
            .clk   (clk),
            .en    (acc),
            .we    (wen[b]),
            .addr  (row_addr[b]),
            .wdata (wdata[b]),
            .rdata (rdata[b])
        );
    end

    // byte rotation and sign or zero extension of the read data
    lsub_load_align u_align (
        .info  (s1_info_reg),
        .rdata (rdata),
        .value (aligned)
    );

    always_comb
    begin
        s1_info_next.is_store    = (req.opcode == OP_STORE);
        s1_info_next.size_log2   = req.size_log2;
        s1_info_next.sign_extend = req.sign_extend;
        s1_info_next.lane        = lane;

        s1_valid_next = acc || (s1_valid_reg && !advance);

        out_valid_next = advance || (out_valid_reg && !rsp.ready);
        out_data_next  = advance ? aligned : out_data_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_info_reg <= s1_info_next;
        end
        out_data_reg <= out_data_next;
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.load_value = out_data_reg;

`ifndef ASSERT_OFF
    // a store item enables exactly as many banks as it has bytes
    a_store_lanes: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && req.opcode == OP_STORE) |->
            ($countones({wen[7], wen[6], wen[5], wen[4], wen[3], wen[2], wen[1], wen[0]})
             == (32'd1 << req.size_log2)))
        else $error("store byte enable count mismatch");

    // no bank is written without an accepted store
    a_no_stray_write: assert property (@(posedge clk) disable iff (!rst_n)
        (wen[0] || wen[1] || wen[2] || wen[3] || wen[4] || wen[5] || wen[6] || wen[7])
            |-> (acc && req.opcode == OP_STORE))
        else $error("bank write outside an accepted store");

    // a store that leaves stage 1 shows up as a zero result
    a_store_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && s1_info_reg.is_store) |=> (rsp.valid && rsp.load_value == 64'd0))
        else $error("store result not zero");
`endif

endmodule

[rtl/core/lsub_bank.sv]
module lsub_bank
    import lsub_pkg::*;
#(
    parameter int unsigned DEPTH = LSUB_MEM_BYTES / LSUB_LANES
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  lsub_byte_t               wdata,
    output lsub_byte_t               rdata
);

    lsub_byte_t mem_reg [DEPTH];
    lsub_byte_t rdata_reg;

    // single port, read data registered, no reset on contents
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem_reg[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem_reg[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/lsub_addr_gen.sv]
module lsub_addr_gen
    import lsub_pkg::*;
#(
    parameter int unsigned MEM_BYTES = LSUB_MEM_BYTES
) (
    input  logic                       acc,
    input  logic                       opcode,
    input  logic [1:0]                 size_log2,
    input  logic signed [63:0]         base_value,
    input  logic signed [11:0]         offset,
    input  logic signed [63:0]         store_value,
    output logic [$clog2(MEM_BYTES)-LSUB_LANE_W-1:0] row_addr [LSUB_LANES],
    output logic                       wen [LSUB_LANES],
    output lsub_byte_t                 wdata [LSUB_LANES],
    output logic [LSUB_LANE_W-1:0]     lane
);

    localparam int unsigned ADDR_W = $clog2(MEM_BYTES);
    localparam int unsigned ROW_W  = ADDR_W - LSUB_LANE_W;

    logic [63:0]                   off_ext;
    logic [ADDR_W-1:0]             addr;
    logic [ROW_W-1:0]              row;
    logic [LSUB_LANE_W:0]          nbytes;
    logic                          is_store;

    // address wraps modulo the memory size by truncation
    assign off_ext  = {{52{offset[11]}}, offset};
    assign addr     = base_value[ADDR_W-1:0] + off_ext[ADDR_W-1:0];
    assign row      = addr[ADDR_W-1:LSUB_LANE_W];
    assign lane     = addr[LSUB_LANE_W-1:0];
    assign nbytes   = (LSUB_LANE_W+1)'(1) << size_log2;
    assign is_store = (opcode == OP_STORE);

    always_comb
    begin
        logic [LSUB_LANE_W-1:0] k;
        for (int b = 0; b < LSUB_LANES; b++)
        begin
            // byte index of the access that lands in this bank
            k = LSUB_LANE_W'(b) - lane;
            // banks below the start lane take the next row
            row_addr[b] = row + ROW_W'(LSUB_LANE_W'(b) < lane);
            wen[b]      = acc && is_store && ({1'b0, k} < nbytes);
            wdata[b]    = store_value[8*k +: 8];
        end
    end

endmodule

[rtl/core/lsub_load_align.sv]
module lsub_load_align
    import lsub_pkg::*;
(
    input  lsub_ld_info_t info,
    input  lsub_byte_t    rdata [LSUB_LANES],
    output logic [63:0]   value
);

    logic [63:0] raw;
    logic        sx;

    // rotate bank bytes so that the first byte of the access is byte 0
    always_comb
    begin
        for (int k = 0; k < LSUB_LANES; k++)
        begin
            raw[8*k +: 8] = rdata[info.lane + LSUB_LANE_W'(k)];
        end
    end

    assign sx = info.sign_extend;

    always_comb
    begin
        if (info.is_store)
        begin
            value = '0;
        end
        else
        begin
            unique case (info.size_log2)
                SZ_BYTE:   value = {{56{sx & raw[7]}}, raw[7:0]};
                SZ_HALF:   value = {{48{sx & raw[15]}}, raw[15:0]};
                SZ_WORD:   value = {{32{sx & raw[31]}}, raw[31:0]};
                SZ_DOUBLE: value = raw;
                default:   value = raw;
            endcase
        end
    end

endmodule

[tb/tb.sv]
module tb;
    import lsub_pkg::*;

    localparam int ADDR_W        = $clog2(LSUB_MEM_BYTES);
    localparam int RANDOM_ITEMS  = 750;
    localparam int DRAIN_EVERY   = 250;
    localparam int IDLE_LIMIT    = 1000;
    localparam int TAIL_CYCLES   = 8;

    // receiver stall patterns
    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_RANDOM,
        RX_PERIODIC,
        RX_SLOW
    } rx_mode_e;

    // keeps a byte image of the data memory and the results still owed by the block, zero for a store
    class load_value_board;
        bit [7:0]    mem_image [LSUB_MEM_BYTES];
        logic [63:0] due_load_values [$];
        int unsigned errors = 0;

        function void note_access(input logic op, input logic [1:0] sz, input logic sx,
                                  input logic [63:0] base, input logic [11:0] off,
                                  input logic [63:0] data);
            logic [63:0] ea;
            logic [63:0] raw;
            logic [63:0] value;
            int unsigned idx;
            ea  = base + {{52{off[11]}}, off};
            raw = '0;
            for (int k = 0; k < (1 << sz); k++)
            begin
                idx = (ea + k) % LSUB_MEM_BYTES;
                if (op == OP_STORE)
                    mem_image[idx] = data[8*k +: 8];
                else
                    raw[8*k +: 8] = mem_image[idx];
            end
            if (op == OP_STORE)
                value = '0;
            else
                case (sz)
                    SZ_BYTE: value = sx ? {{56{raw[7]}}, raw[7:0]} : {56'd0, raw[7:0]};
                    SZ_HALF: value = sx ? {{48{raw[15]}}, raw[15:0]} : {48'd0, raw[15:0]};
                    SZ_WORD: value = sx ? {{32{raw[31]}}, raw[31:0]} : {32'd0, raw[31:0]};
                    default: value = raw;
                endcase
            due_load_values.push_back(value);
        endfunction

        function void check_load(input logic [63:0] got);
            logic [63:0] want;
            if (due_load_values.size() == 0)
            begin
                $display("%0t unexpected result: expected none, actual %h", $time, got);
                errors++;
            end
            else
            begin
                want = due_load_values.pop_front();
                if (got !== want)
                begin
                    $display("%0t load_value mismatch: expected %h, actual %h",
                             $time, want, got);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return due_load_values.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    lsub_req_if req_bus();
    lsub_rsp_if rsp_bus();

    load_store_unit_byte_memory_top uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    load_value_board board = new;

    // bytes that some store already sent has covered, so loads never touch unwritten memory
    bit written_map [LSUB_MEM_BYTES];

    int       idle_cycles = 0;
    int       burst_left  = 0;
    logic [15:0] stall_tick = '0;
    rx_mode_e stall_mode  = RX_ALWAYS;

    always #2 clk = ~clk;

    // monitor: every accepted item goes into the predictor, every result is checked
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_bus.valid && req_bus.ready)
                board.note_access(req_bus.opcode, req_bus.size_log2, req_bus.sign_extend,
                                  req_bus.base_value, req_bus.offset, req_bus.store_value);
            if (rsp_bus.valid && rsp_bus.ready)
                board.check_load(rsp_bus.load_value);
            idle_cycles <= ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
                           ? 0 : idle_cycles + 1;
        end
    end

    // result side back-pressure, with a new random pattern picked whenever the low seven bits of stall_tick are zero
    always @(posedge clk)
    begin
        stall_tick <= stall_tick + 1'b1;
        if (stall_tick[6:0] == 7'd0)
            stall_mode <= rx_mode_e'($urandom_range(3));
        case (stall_mode)
            RX_ALWAYS:   rsp_bus.ready <= 1'b1;
            RX_RANDOM:   rsp_bus.ready <= ($urandom_range(9) < 7);
            RX_PERIODIC: rsp_bus.ready <= (stall_tick[2:0] != 3'd5) && (stall_tick[2:0] != 3'd6);
            default:     rsp_bus.ready <= (stall_tick[3:0] < 4'd3);
        endcase
    end

    // watchdog: nothing moving for too long
    initial
    begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    // random upper bits, low bits chosen so that base plus offset lands on target
    function automatic logic [63:0] aim_base(input logic [ADDR_W-1:0] target,
                                             input logic [11:0] off);
        logic [63:0] b;
        b = {$urandom, $urandom};
        b[ADDR_W-1:0] = target - ADDR_W'({{52{off[11]}}, off});
        return b;
    endfunction

    // present one item, hold it until taken, then either carry on the burst or go quiet
    task automatic send_access(input logic op, input logic [1:0] sz, input logic sx,
                               input logic [63:0] base, input logic [11:0] off,
                               input logic [63:0] data);
        logic [63:0]       ea;
        logic [ADDR_W-1:0] idx;
        ea = base + {{52{off[11]}}, off};
        if (op == OP_STORE)
            for (int k = 0; k < (1 << sz); k++)
            begin
                idx = ea[ADDR_W-1:0] + ADDR_W'(k);
                written_map[idx] = 1'b1;
            end
        req_bus.valid       <= 1'b1;
        req_bus.opcode      <= op;
        req_bus.size_log2   <= sz;
        req_bus.sign_extend <= sx;
        req_bus.base_value  <= base;
        req_bus.offset      <= off;
        req_bus.store_value <= data;
        do
            @(posedge clk);
        while (!req_bus.ready);
        if (burst_left == 0)
        begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(12, 1)) @(posedge clk);
            burst_left = $urandom_range(20);
        end
        else
            burst_left--;
    endtask

    // sender stops until every owed result has come back
    task automatic hold_until_drained();
        req_bus.valid <= 1'b0;
        do
            @(posedge clk);
        while (board.pending() != 0);
    endtask

    // random access aimed mostly at two hot windows, loads only where every byte is already written
    task automatic random_access();
        logic              op;
        logic [1:0]        sz;
        logic              sx;
        logic [11:0]       off;
        logic [63:0]       data;
        logic [ADDR_W-1:0] target;
        op   = ($urandom_range(99) < 45) ? OP_STORE : OP_LOAD;
        sz   = 2'($urandom_range(3));
        sx   = 1'($urandom);
        off  = 12'($urandom);
        data = {$urandom, $urandom};
        case ($urandom_range(9))
            0, 1, 2, 3, 4: target = ADDR_W'($urandom_range(47));
            5, 6, 7:       target = ADDR_W'(LSUB_MEM_BYTES - 1 - $urandom_range(23));
            default:       target = ADDR_W'($urandom);
        endcase
        if (op == OP_LOAD)
            for (int k = 0; k < (1 << sz); k++)
                if (!written_map[ADDR_W'(target + k)])
                    op = OP_STORE;
        send_access(op, sz, sx, aim_base(target, off), off, data);
    endtask

    initial
    begin
        req_bus.valid       = 1'b0;
        req_bus.opcode      = OP_LOAD;
        req_bus.size_log2   = SZ_BYTE;
        req_bus.sign_extend = 1'b0;
        req_bus.base_value  = '0;
        req_bus.offset      = '0;
        req_bus.store_value = '0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // base and offset extremes, signed sum overflows past the largest and below the smallest 64-bit value
        send_access(OP_STORE, SZ_DOUBLE, 1'b0, 64'h8000_0000_0000_0000, 12'h800,
                    64'h8000_0000_0000_0001);
        send_access(OP_STORE, SZ_DOUBLE, 1'b1, 64'h7FFF_FFFF_FFFF_FFFF, 12'h7FF,
                    64'h7FFF_FFFF_FFFF_FFFF);

        // double store running off the top of memory into address zero
        send_access(OP_STORE, SZ_DOUBLE, 1'b0,
                    aim_base(ADDR_W'(LSUB_MEM_BYTES - 4), 12'h123), 12'h123,
                    64'hF1E2_D3C4_B5A6_9788);

        // loads of every size at the top, wrapping for all but bytes, both extension modes, negative sign bits
        send_access(OP_LOAD, SZ_DOUBLE, 1'b0,
                    aim_base(ADDR_W'(LSUB_MEM_BYTES - 4), 12'hFFF), 12'hFFF, '0);
        send_access(OP_LOAD, SZ_DOUBLE, 1'b1,
                    aim_base(ADDR_W'(LSUB_MEM_BYTES - 4), 12'h001), 12'h001, '0);
        send_access(OP_LOAD, SZ_WORD, 1'b1,
                    aim_base(ADDR_W'(LSUB_MEM_BYTES - 2), 12'h400), 12'h400, '0);
        send_access(OP_LOAD, SZ_WORD, 1'b0,
                    aim_base(ADDR_W'(LSUB_MEM_BYTES - 2), 12'hC00), 12'hC00, '0);
        send_access(OP_LOAD, SZ_HALF, 1'b1,
                    aim_base(ADDR_W'(LSUB_MEM_BYTES - 1), 12'h0AA), 12'h0AA, '0);
        send_access(OP_LOAD, SZ_HALF, 1'b0,
                    aim_base(ADDR_W'(LSUB_MEM_BYTES - 1), 12'h555), 12'h555, '0);
        send_access(OP_LOAD, SZ_BYTE, 1'b1,
                    aim_base(ADDR_W'(LSUB_MEM_BYTES - 1), 12'h000), 12'h000, '0);
        send_access(OP_LOAD, SZ_BYTE, 1'b0,
                    aim_base(ADDR_W'(LSUB_MEM_BYTES - 1), 12'h800), 12'h800, '0);

        // narrow stores, all-ones and all-zero data, positive and negative tops
        send_access(OP_STORE, SZ_BYTE, 1'b0, aim_base(ADDR_W'(16), 12'h010), 12'h010,
                    64'hFFFF_FFFF_FFFF_FFFF);
        send_access(OP_STORE, SZ_BYTE, 1'b1, aim_base(ADDR_W'(17), 12'h7FF), 12'h7FF,
                    64'h0000_0000_0000_0000);
        send_access(OP_STORE, SZ_HALF, 1'b0, aim_base(ADDR_W'(18), 12'h801), 12'h801,
                    64'h0000_0000_0000_7FFF);
        send_access(OP_STORE, SZ_WORD, 1'b0, aim_base(ADDR_W'(20), 12'h0F0), 12'h0F0,
                    64'h0123_4567_8000_0000);

        send_access(OP_LOAD, SZ_BYTE, 1'b1, aim_base(ADDR_W'(16), 12'h321), 12'h321, '0);
        send_access(OP_LOAD, SZ_BYTE, 1'b1, aim_base(ADDR_W'(17), 12'hF0F), 12'hF0F, '0);
        send_access(OP_LOAD, SZ_HALF, 1'b1, aim_base(ADDR_W'(18), 12'h00F), 12'h00F, '0);
        send_access(OP_LOAD, SZ_WORD, 1'b1, aim_base(ADDR_W'(20), 12'h7FF), 12'h7FF, '0);
        send_access(OP_LOAD, SZ_WORD, 1'b0, aim_base(ADDR_W'(20), 12'h800), 12'h800, '0);
        send_access(OP_LOAD, SZ_DOUBLE, 1'b1, aim_base(ADDR_W'(16), 12'h246), 12'h246, '0);

        // read back the extreme-address stores
        send_access(OP_LOAD, SZ_DOUBLE, 1'b1,
                    aim_base(ADDR_W'(LSUB_MEM_BYTES - 2048), 12'h000), 12'h000, '0);
        send_access(OP_LOAD, SZ_DOUBLE, 1'b0, aim_base(ADDR_W'(12'h7FE), 12'h9AB), 12'h9AB, '0);

        hold_until_drained();

        // random part with a full drain now and then
        for (int n = 1; n <= RANDOM_ITEMS; n++)
        begin
            random_access();
            if (n % DRAIN_EVERY == 0)
                hold_until_drained();
        end

        hold_until_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (board.errors == 0 && board.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
